@@ src/spld_pkg.sv @@
// ----------------------------------------------------------------------------
// spld_pkg
// Constants for the sync pattern, length prefixed deframer: frame geometry,
// field widths, the maximum body length reset value and configuration register indexes.
// ----------------------------------------------------------------------------
package spld_pkg;

    localparam int HEADER_LEN = 4;
    localparam int SIZE_POS   = 0;
    localparam int SYNC_LEN   = 8;

    localparam int POS_W   = 17;
    localparam int MATCH_W = 4;
    localparam int LEN_W   = 16;

    localparam logic [LEN_W-1:0] MAX_BODY_LEN_RST = 16'd4096;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY_LEN = 2'd1;

endpackage

@@ src/sync_pattern_length_deframer_top.sv @@
// ----------------------------------------------------------------------------
// sync_pattern_length_deframer_top
// Hunts for an eight byte sync pattern in a received byte stream, reads a
// big-endian length from the header and emits header and body words with
// their frame offset and an end mark.
// ----------------------------------------------------------------------------
// path: a word accepted into the input register is processed from there and its
//   result is held in the result register until it is taken downstream
// throughput: one input word per cycle while the result channel does not stall,
//   set by the single pass of compare and counter logic between the input register and the result register
// reset: rst_n asynchronous, clears hunt, frame and buffer state, loads the
//   sync pattern with zero and the maximum body length with 4096
module sync_pattern_length_deframer_top
    import spld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 buffer_ready,
    input  logic                 sink_ready,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           frame_byte,
    output logic [POS_W-1:0]     byte_offset,
    output logic                 frame_last,
    output logic                 oversize,
    output logic                 handed_over,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam logic [POS_W-1:0]   HDR_LEN_P  = POS_W'(HEADER_LEN);
    localparam logic [POS_W-1:0]   SIZE_HI_P  = POS_W'(SIZE_POS);
    localparam logic [POS_W-1:0]   SIZE_LO_P  = POS_W'(SIZE_POS + 1);
    localparam logic [MATCH_W-1:0] SYNC_LEN_P = MATCH_W'(SYNC_LEN);

    // configuration registers
    logic [63:0]          sync_pattern_reg;
    logic [LEN_W-1:0]     max_body_len_reg;

    // input register
    logic                 in_vld_reg;
    logic [7:0]           byte_reg;
    logic                 buf_rdy_reg;
    logic                 sink_rdy_reg;

    // deframer state
    logic [MATCH_W-1:0]   match_count_reg, match_count_next;
    logic                 holding_reg, holding_next;
    logic [POS_W-1:0]     write_pos_reg, write_pos_next;
    logic [POS_W-1:0]     frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]     length_capture_reg, length_capture_next;

    // result register
    logic                 out_vld_reg;
    logic [7:0]           frame_byte_reg;
    logic [POS_W-1:0]     byte_offset_reg;
    logic                 frame_last_reg;
    logic                 oversize_reg;
    logic                 handed_over_reg;

    // single pass results
    logic                 emit;
    logic                 last_c;
    logic                 over_c;
    logic                 handed_c;
    logic                 proc_go;
    logic                 out_free;
    logic [7:0]           sync_byte;
    logic [MATCH_W-1:0]   match_inc;

    // configuration is always taken; the user must write it only while idle, not enforced by the block
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg <= '0;
            max_body_len_reg <= MAX_BODY_LEN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SYNC_PATTERN: sync_pattern_reg <= cfg_data;
                CFG_MAX_BODY_LEN: max_body_len_reg <= cfg_data[LEN_W-1:0];
                default:          ; // unknown index, write ignored
            endcase
        end
    end

    // pattern byte selected by the low three bits of the match count
    assign sync_byte = sync_pattern_reg[{match_count_reg[2:0], 3'b000} +: 8];
    assign match_inc = match_count_reg + 1'b1;

    // one pass over the registered word
    always_comb
    begin
        match_count_next    = match_count_reg;
        holding_next        = holding_reg;
        write_pos_next      = write_pos_reg;
        frame_len_next      = frame_len_reg;
        length_capture_next = length_capture_reg;
        emit                = 1'b0;
        last_c              = 1'b0;
        over_c              = 1'b0;
        handed_c            = 1'b0;

        if (holding_reg || buf_rdy_reg)
        begin
            // take a fresh buffer if none is held
            holding_next = 1'b1;
            if (match_count_reg < SYNC_LEN_P)
            begin
                // hunting: a failing byte is not retried against the first byte
                if (byte_reg == sync_byte)
                    match_count_next = match_inc;
                else
                    match_count_next = '0;
                if (byte_reg == sync_byte && match_inc == SYNC_LEN_P)
                begin
                    write_pos_next      = '0;
                    length_capture_next = '0;
                    frame_len_next      = HDR_LEN_P;
                end
            end
            else
            begin
                emit = 1'b1;
                if (write_pos_reg == SIZE_HI_P)
                    length_capture_next = {byte_reg, length_capture_reg[7:0]};
                else if (write_pos_reg == SIZE_LO_P)
                    length_capture_next = {length_capture_reg[15:8], byte_reg};
                write_pos_next = write_pos_reg + 1'b1;

                // end of header: accept the length or close as oversize
                if (write_pos_next == HDR_LEN_P)
                begin
                    if (length_capture_next < max_body_len_reg)
                        frame_len_next = frame_len_reg + POS_W'(length_capture_next);
                    else
                    begin
                        match_count_next = '0;
                        over_c           = 1'b1;
                    end
                end

                if (write_pos_next == frame_len_next)
                begin
                    last_c           = 1'b1;
                    match_count_next = '0;
                    if (sink_rdy_reg)
                    begin
                        // frame handed over, buffer released
                        holding_next = 1'b0;
                        handed_c     = 1'b1;
                    end
                end
            end
        end
    end

    // the word in the input register moves on unless its result would
    // overwrite a result still waiting downstream
    assign out_free = !out_vld_reg || !out_stall;
    assign proc_go  = in_vld_reg && (!emit || out_free);
    assign in_stall = in_vld_reg && !proc_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_vld_reg <= 1'b1;
        else if (proc_go)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg     <= rx_byte;
            buf_rdy_reg  <= buffer_ready;
            sink_rdy_reg <= sink_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg    <= '0;
            holding_reg        <= 1'b0;
            write_pos_reg      <= '0;
            frame_len_reg      <= '0;
            length_capture_reg <= '0;
        end
        else if (proc_go)
        begin
            match_count_reg    <= match_count_next;
            holding_reg        <= holding_next;
            write_pos_reg      <= write_pos_next;
            frame_len_reg      <= frame_len_next;
            length_capture_reg <= length_capture_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (proc_go && emit)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && emit)
        begin
            frame_byte_reg  <= byte_reg;
            byte_offset_reg <= write_pos_reg;
            frame_last_reg  <= last_c;
            oversize_reg    <= last_c && over_c;
            handed_over_reg <= handed_c;
        end
    end

    assign out_valid   = out_vld_reg;
    assign frame_byte  = frame_byte_reg;
    assign byte_offset = byte_offset_reg;
    assign frame_last  = frame_last_reg;
    assign oversize    = oversize_reg;
    assign handed_over = handed_over_reg;

endmodule
